### design/rmq_pkg.sv
package rmq_pkg;

  typedef struct packed {
    logic [9:0]         node_index;
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } rmq_in_t;

  typedef struct packed {
    logic [9:0]         out_index;
    logic [14:0]        qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
  } rmq_out_t;

  // travels beside the lanes: index and negate flags for x, y, z
  typedef struct packed {
    logic [9:0] index;
    logic [2:0] neg;
  } rmq_side_t;

  localparam int NLANE = 4;

endpackage

### design/rotation_matrix_to_quaternion.sv
// Channel  Direction  Ports                          Payload
// in       input      in_valid / in_ready / in_data  node index, 3x3 matrix (Q2.14)
// out      output     out_valid / out_ready / out_data  index, unit quaternion (Q1.14)
//
// One item per cycle while the pipe advances (see below): a sum stage,
// one restoring divide step per stage, one square-root step per stage,
// then the output register.
// Synchronous active-low reset clears the valid bits only.
// The whole pipe advances while the output register is empty or being taken;
// a stall freezes every stage, so nothing is lost or repeated.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rmq_pkg::rmq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rmq_pkg::rmq_out_t out_data
);
  import rmq_pkg::*;

  // signed sum width, total width
  localparam int SSW = (FRAC_BITS + 2 > 19) ? FRAC_BITS + 2 : 19;
  localparam int TW  = SSW + 1;
  // quotient s * 2^(2F) / total reaches 2^(2F); its root reaches 2^F
  localparam int QW  = 2 * FRAC_BITS + 1;
  localparam int RW  = FRAC_BITS + 1;
  localparam int ND  = 2 * FRAC_BITS;

  logic adv;
  logic out_valid_r;
  rmq_out_t out_data_r, out_data_nxt;

  // divide chain, index 0 is the sum stage output
  logic               dv   [ND+1];
  rmq_side_t          dside[ND+1];
  logic [3:0][TW-1:0] drem [ND+1];
  logic [3:0][QW-1:0] dquo [ND+1];
  logic [TW-1:0]      dden [ND+1];

  // root chain, index 0 is fed from the divide chain
  logic               sv    [RW+1];
  rmq_side_t          sside [RW+1];
  logic [3:0][QW-1:0] srad  [RW+1];
  logic [3:0][RW+1:0] srem  [RW+1];
  logic [3:0][RW-1:0] sroot [RW+1];

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  rmq_sum #(.FRAC_BITS(FRAC_BITS), .SSW(SSW), .TW(TW), .QW(QW)) u_sum (
    .clk(clk), .rst_n(rst_n), .en(adv),
    .in_vld(in_valid), .in_data(in_data),
    .vld_r(dv[0]), .side_r(dside[0]), .rem_r(drem[0]), .quo_r(dquo[0]), .den_r(dden[0])
  );

  for (genvar k = 0; k < ND; k++) begin : g_div
    rmq_div_step #(.TW(TW), .QW(QW), .BIT(ND - 1 - k)) u_div (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .in_vld(dv[k]), .in_side(dside[k]), .in_rem(drem[k]), .in_quo(dquo[k]),
      .in_den(dden[k]),
      .vld_r(dv[k+1]), .side_r(dside[k+1]), .rem_r(drem[k+1]), .quo_r(dquo[k+1]),
      .den_r(dden[k+1])
    );
  end

  assign sv[0]    = dv[ND];
  assign sside[0] = dside[ND];
  assign srad[0]  = dquo[ND];
  assign srem[0]  = '0;
  assign sroot[0] = '0;

  // most significant root bit first
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    rmq_sqrt_step #(.QW(QW), .RW(RW), .STEP(RW - 1 - j)) u_sqrt (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .in_vld(sv[j]), .in_side(sside[j]), .in_rad(srad[j]), .in_rem(srem[j]),
      .in_root(sroot[j]),
      .vld_r(sv[j+1]), .side_r(sside[j+1]), .rad_r(srad[j+1]), .rem_r(srem[j+1]),
      .root_r(sroot[j+1])
    );
  end

  // final formatting: truncate to field width, negate where flagged
  logic [RW+15:0] mag [NLANE];
  logic [15:0]    vec [3];

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      mag[i] = (RW + 16)'(sroot[RW][i]);
    end
    for (int i = 0; i < 3; i++) begin
      vec[i] = sside[RW].neg[i] ? (16'd0 - mag[i+1][15:0]) : mag[i+1][15:0];
    end
    out_data_nxt.out_index = sside[RW].index;
    out_data_nxt.qw = mag[0][14:0];
    out_data_nxt.qx = vec[0];
    out_data_nxt.qy = vec[1];
    out_data_nxt.qz = vec[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sv[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/rmq_sum.sv
module rmq_sum #(
  parameter int FRAC_BITS = 14,
  parameter int SSW = 19,
  parameter int TW = 20,
  parameter int QW = 29
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  rmq_pkg::rmq_in_t      in_data,
  output logic                  vld_r,
  output rmq_pkg::rmq_side_t    side_r,
  output logic [3:0][TW-1:0]    rem_r,
  output logic [3:0][QW-1:0]    quo_r,
  output logic [TW-1:0]         den_r
);
  import rmq_pkg::*;

  localparam int SW = SSW - 1;

  logic signed [SSW-1:0] one, a, b, c;
  logic signed [SSW-1:0] raw [NLANE];
  logic [3:0][SW-1:0]    s;
  logic [TW-1:0]         tot;
  logic signed [16:0]    d0, d1, d2;
  rmq_side_t             side_nxt;
  logic [3:0][TW-1:0]    rem_nxt;
  logic [3:0][QW-1:0]    quo_nxt;

  always_comb begin
    one = SSW'(1) <<< FRAC_BITS;
    a = SSW'(in_data.m00);
    b = SSW'(in_data.m11);
    c = SSW'(in_data.m22);
    raw[0] = one + a + b + c;
    raw[1] = one + a - b - c;
    raw[2] = one - a + b - c;
    raw[3] = one - a - b + c;
    tot = '0;
    for (int i = 0; i < NLANE; i++) begin
      s[i] = raw[i][SSW-1] ? '0 : raw[i][SW-1:0];
      tot = tot + TW'(s[i]);
    end
    // restoring divide seed: integer quotient is 0 or 1 since s <= total
    for (int i = 0; i < NLANE; i++) begin
      quo_nxt[i] = '0;
      quo_nxt[i][QW-1] = (TW'(s[i]) == tot);
      rem_nxt[i] = (TW'(s[i]) == tot) ? '0 : TW'(s[i]);
    end
    d0 = 17'(in_data.m21) - 17'(in_data.m12);
    d1 = 17'(in_data.m02) - 17'(in_data.m20);
    d2 = 17'(in_data.m10) - 17'(in_data.m01);
    side_nxt.index = in_data.node_index;
    side_nxt.neg = {d2[16] || (d2 == '0), d1[16] || (d1 == '0), d0[16] || (d0 == '0)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_nxt;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      den_r  <= tot;
    end
  end

endmodule

### design/rmq_div_step.sv
module rmq_div_step #(
  parameter int TW = 20,
  parameter int QW = 29,
  parameter int BIT = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  rmq_pkg::rmq_side_t in_side,
  input  logic [3:0][TW-1:0] in_rem,
  input  logic [3:0][QW-1:0] in_quo,
  input  logic [TW-1:0]      in_den,
  output logic               vld_r,
  output rmq_pkg::rmq_side_t side_r,
  output logic [3:0][TW-1:0] rem_r,
  output logic [3:0][QW-1:0] quo_r,
  output logic [TW-1:0]      den_r
);
  import rmq_pkg::*;

  logic [TW:0]        r2 [NLANE];
  logic [TW:0]        dif [NLANE];
  logic [3:0][TW-1:0] rem_nxt;
  logic [3:0][QW-1:0] quo_nxt;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      r2[i] = {in_rem[i], 1'b0};
      dif[i] = r2[i] - {1'b0, in_den};
      quo_nxt[i] = in_quo[i];
      quo_nxt[i][BIT] = !dif[i][TW];
      rem_nxt[i] = dif[i][TW] ? r2[i][TW-1:0] : dif[i][TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= in_side;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      den_r  <= in_den;
    end
  end

endmodule

### design/rmq_sqrt_step.sv
module rmq_sqrt_step #(
  parameter int QW = 29,
  parameter int RW = 15,
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  rmq_pkg::rmq_side_t   in_side,
  input  logic [3:0][QW-1:0]   in_rad,
  input  logic [3:0][RW+1:0]   in_rem,
  input  logic [3:0][RW-1:0]   in_root,
  output logic                 vld_r,
  output rmq_pkg::rmq_side_t   side_r,
  output logic [3:0][QW-1:0]   rad_r,
  output logic [3:0][RW+1:0]   rem_r,
  output logic [3:0][RW-1:0]   root_r
);
  import rmq_pkg::*;

  localparam int PW = 2 * RW;

  logic [PW-1:0]        pv [NLANE];
  logic [RW+1:0]        remx [NLANE];
  logic [RW+1:0]        trial [NLANE];
  logic [RW+1:0]        dif [NLANE];
  logic [3:0][RW+1:0]   rem_nxt;
  logic [3:0][RW-1:0]   root_nxt;

  // one result bit per stage, two radicand bits brought down
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      pv[i] = PW'(in_rad[i]);
      remx[i] = {in_rem[i][RW-1:0], pv[i][2*STEP+1], pv[i][2*STEP]};
      trial[i] = {in_root[i], 2'b01};
      dif[i] = remx[i] - trial[i];
      rem_nxt[i] = (remx[i] >= trial[i]) ? dif[i] : remx[i];
      root_nxt[i] = {in_root[i][RW-2:0], remx[i] >= trial[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= in_side;
      rad_r  <= in_rad;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

endmodule

### verif/rotation_matrix_to_quaternion_tb.sv
module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int FRAC = 14;
  localparam int PIPE_LAT = 2 + 2 * FRAC + (FRAC + 1);
  localparam int N_RANDOM = 1300;

  // idling profiles, stepped through by the stimulus process
  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  rmq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rmq_out_t out_data;

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rmq_in_t    matrix_q[$];     // items waiting to be offered
  rmq_out_t   quat_q[$];       // predicted quaternions, oldest first
  idle_mode_t idle_mode = IDLE_NONE;
  int         hold_cycles = 0; // long receiver hold-off, counted below
  int         n_sent = 0;
  int         n_bad = 0;
  bit         stim_done = 1'b0;

  // floor(sqrt(v)), bit by bit
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // sign a magnitude: negative unless the off-diagonal difference is > 0
  function automatic logic [15:0] apply_sign(longint unsigned mag, longint d);
    return (d > 0) ? mag[15:0] : (16'd0 - mag[15:0]);
  endfunction

  function automatic rmq_out_t quat_of(rmq_in_t m);
    longint one, a, b, c;
    longint s[4];
    longint unsigned tot;
    longint unsigned mag[4];
    rmq_out_t q;
    one = longint'(1) << FRAC;
    a = m.m00;
    b = m.m11;
    c = m.m22;
    s[0] = one + a + b + c;
    s[1] = one + a - b - c;
    s[2] = one - a + b - c;
    s[3] = one - a - b + c;
    tot = 0;
    for (int i = 0; i < 4; i++) begin
      if (s[i] < 0) s[i] = 0;
      tot += s[i];
    end
    // s <= tot < 2^19, so s << 28 fits in 64 bits and the divide is exact
    for (int i = 0; i < 4; i++)
      mag[i] = root_floor((unsigned'(s[i]) << (2 * FRAC)) / tot);
    q.out_index = m.node_index;
    q.qw = mag[0][14:0];
    q.qx = apply_sign(mag[1], longint'(m.m21) - longint'(m.m12));
    q.qy = apply_sign(mag[2], longint'(m.m02) - longint'(m.m20));
    q.qz = apply_sign(mag[3], longint'(m.m10) - longint'(m.m01));
    return q;
  endfunction

  function automatic logic [15:0] rand_elem();
    int unsigned k;
    k = $urandom_range(0, 9);
    case (k)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h4000;
      3: return 16'hc000;
      4: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // mostly elements in [-1.0, 1.0], otherwise extreme values or any 16-bit pattern
  function automatic rmq_in_t rand_matrix();
    rmq_in_t m;
    m.node_index = 10'($urandom());
    if ($urandom_range(0, 3) == 0) begin
      m.m00 = rand_elem(); m.m01 = rand_elem(); m.m02 = rand_elem();
      m.m10 = rand_elem(); m.m11 = rand_elem(); m.m12 = rand_elem();
      m.m20 = rand_elem(); m.m21 = rand_elem(); m.m22 = rand_elem();
    end else begin
      m.m00 = 16'($urandom_range(0, 32768) - 16384);
      m.m01 = 16'($urandom_range(0, 32768) - 16384);
      m.m02 = 16'($urandom_range(0, 32768) - 16384);
      m.m10 = 16'($urandom_range(0, 32768) - 16384);
      m.m11 = 16'($urandom_range(0, 32768) - 16384);
      m.m12 = 16'($urandom_range(0, 32768) - 16384);
      m.m20 = 16'($urandom_range(0, 32768) - 16384);
      m.m21 = 16'($urandom_range(0, 32768) - 16384);
      m.m22 = 16'($urandom_range(0, 32768) - 16384);
    end
    return m;
  endfunction

  function automatic rmq_in_t mk(logic [9:0] idx, logic [15:0] a00, logic [15:0] a01,
                                 logic [15:0] a02, logic [15:0] a10, logic [15:0] a11,
                                 logic [15:0] a12, logic [15:0] a20, logic [15:0] a21,
                                 logic [15:0] a22);
    rmq_in_t m;
    m = {idx, a00, a01, a02, a10, a11, a12, a20, a21, a22};
    return m;
  endfunction

  // Driver: one pending item offered at a time, held until taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        quat_q.push_back(quat_of(in_data));
        n_sent <= n_sent + 1;
      end
      if (!in_valid || in_ready) begin
        // slot is free this edge: maybe offer the next item
        if (matrix_q.size() != 0 &&
            !((idle_mode == IDLE_SEND && $urandom_range(0, 99) < 46) ||
              (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 20))) begin
          in_data  <= matrix_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with the long hold-off counted here.
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else if (idle_mode == IDLE_RECV) begin
        out_ready <= ($urandom_range(0, 99) >= 46);
      end else if (idle_mode == IDLE_BOTH) begin
        out_ready <= ($urandom_range(0, 99) >= 20);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: compare each taken item with the oldest prediction.
  always @(posedge clk) begin
    rmq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (quat_q.size() == 0) begin
        n_bad = n_bad + 1;
        if (n_bad <= 10) $display("unexpected item: %p", out_data);
      end else begin
        want = quat_q.pop_front();
        if (out_data.out_index !== want.out_index || out_data.qw !== want.qw ||
            out_data.qx !== want.qx || out_data.qy !== want.qy ||
            out_data.qz !== want.qz) begin
          n_bad = n_bad + 1;
          if (n_bad <= 10)
            $display("mismatch idx exp %0d got %0d | w %0d/%0d x %0d/%0d y %0d/%0d z %0d/%0d",
                     want.out_index, out_data.out_index, want.qw, out_data.qw,
                     want.qx, out_data.qx, want.qy, out_data.qy,
                     want.qz, out_data.qz);
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: identity, half-turns, extremes, zero and negative differences
    matrix_q.push_back(mk(10'd0, 16'h4000, '0, '0, '0, 16'h4000, '0, '0, '0, 16'h4000));
    matrix_q.push_back(mk(10'd1023, 16'h4000, '0, '0, '0, 16'hc000, '0, '0, '0, 16'hc000));
    matrix_q.push_back(mk(10'd2, 16'hc000, '0, '0, '0, 16'h4000, '0, '0, '0, 16'hc000));
    matrix_q.push_back(mk(10'd3, 16'hc000, '0, '0, '0, 16'hc000, '0, '0, '0, 16'h4000));
    // 90 degrees about each axis, both senses
    matrix_q.push_back(mk(10'd4, 16'h4000, '0, '0, '0, '0, 16'hc000, '0, 16'h4000, '0));
    matrix_q.push_back(mk(10'd5, 16'h4000, '0, '0, '0, '0, 16'h4000, '0, 16'hc000, '0));
    matrix_q.push_back(mk(10'd6, '0, '0, 16'h4000, '0, 16'h4000, '0, 16'hc000, '0, '0));
    matrix_q.push_back(mk(10'd7, '0, '0, 16'hc000, '0, 16'h4000, '0, 16'h4000, '0, '0));
    matrix_q.push_back(mk(10'd8, '0, 16'hc000, '0, 16'h4000, '0, '0, '0, '0, 16'h4000));
    matrix_q.push_back(mk(10'd9, '0, 16'h4000, '0, 16'hc000, '0, '0, '0, '0, 16'h4000));
    // non-rotations: field extremes, all zeros and all ones
    matrix_q.push_back(mk(10'h155, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                          16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    matrix_q.push_back(mk(10'h2aa, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          16'h8000, 16'h8000, 16'h8000, 16'h8000));
    matrix_q.push_back(mk(10'd12, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                          16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
    matrix_q.push_back(mk(10'd13, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
                          16'h8000, 16'h7fff, 16'h8000, 16'h7fff));
    matrix_q.push_back(mk(10'd14, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    matrix_q.push_back(mk(10'd15, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                          16'hffff, 16'hffff, 16'hffff, 16'hffff));

    // random phases under each idling profile
    for (int p = 0; p < 4; p++) begin
      idle_mode = idle_mode_t'(p);
      for (int i = 0; i < N_RANDOM / 4; i++) matrix_q.push_back(rand_matrix());
      if (p == 0) begin
        // let the pipe fill against a held-off receiver
        wait (n_sent > 20);
        hold_cycles = 3 * PIPE_LAT;
      end
      while (matrix_q.size() != 0) @(posedge clk);
    end
    wait (!in_valid);
    while (quat_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (n_bad == 0 && quat_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // generous fixed limit on the whole run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
